FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/lifsd_pkg.sv
// Shared constants, codes and helpers for the delayed-synapse LIF neuron.
// No dependencies.
package lifsd_pkg;

    // Action codes of an input item
    localparam logic ACT_SPIKE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_STRENGTH = 2'd2;

    // Field widths
    localparam int POT_W    = 32;
    localparam int WEIGHT_W = 16;
    localparam int STREN_W  = 16;
    localparam int DELAY_W  = 4;
    localparam int DELAY_N  = 16;   // number of distinct delay codes

    // Leak is a fraction of 4096
    localparam int LEAK_W     = 13;
    localparam int LEAK_SHIFT = 12;
    localparam logic [LEAK_W-1:0] LEAK_ONE = 13'd4096;

    typedef logic signed [POT_W-1:0] t_pot;
    typedef logic signed [POT_W:0]   t_pot_wide;

    // Clamp a 33-bit signed sum into the signed 32-bit range
    function automatic t_pot sat32(input t_pot_wide v);
        t_pot r;
        if (v[POT_W] != v[POT_W-1]) begin
            r = v[POT_W] ? {1'b1, {(POT_W-1){1'b0}}} : {1'b0, {(POT_W-1){1'b1}}};
        end else begin
            r = v[POT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/lif_neuron_with_synaptic_delay.sv
// Top level of the leaky integrate-and-fire neuron with a ring of delay slots.
// Depends on lifsd_pkg and lifsd_ram.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   action, weight, strength, delay
//  result    out        o_out_valid / i_out_stall fired, output_value, potential_after
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item can be accepted every cycle unless the input stalls; a tick's result is
// loaded into the result register when the tick leaves stage 1 (the accept edge starts
// the slot read, then the tick waits in stage 1 until the result register is free).
// The delay ring sits in a RAM with one read and one write port; a one-entry
// bypass covers the slot written by the item just ahead.
// Reset clears per-slot valid bits at once, so there is no clearing pass.
// The input stalls only while a tick waits behind a stalled, full result register.
module lif_neuron_with_synaptic_delay
    import lifsd_pkg::*;
#(
    parameter int DELAY_SLOTS   = 16,
    parameter int FRACTION_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic signed [WEIGHT_W-1:0] i_synapse_weight,
    input  logic [STREN_W-1:0]         i_sender_strength,
    input  logic [DELAY_W-1:0]         i_synapse_delay,
    // result items
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_fired,
    output logic [STREN_W-1:0]         o_output_value,
    output logic signed [POT_W-1:0]    o_potential_after,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [POT_W-1:0]           i_cfg_data
);

    localparam int SW = $clog2(DELAY_SLOTS);        // slot index width
    localparam int CW = POT_W + 1 - FRACTION_BITS;  // scaled contribution width
    localparam int PW = POT_W + 1;                  // weight * strength product width
    localparam int KW = POT_W + LEAK_W + 1;         // leak product width

    // Delay code reduced modulo the ring size, built at elaboration
    function automatic logic [DELAY_N*SW-1:0] delay_mod_table();
        logic [DELAY_N*SW-1:0] t;
        int                    v;
        t = '0;
        for (int i = 0; i < DELAY_N; i++) begin
            v = i;
            while (v >= DELAY_SLOTS) begin
                v = v - DELAY_SLOTS;
            end
            t[i*SW +: SW] = SW'(v);
        end
        return t;
    endfunction

    localparam logic [DELAY_N*SW-1:0] DELAY_MOD = delay_mod_table();
    localparam logic [SW:0]           SLOTS_EXT = (SW+1)'(DELAY_SLOTS);
    localparam logic [SW-1:0]         LAST_SLOT = SW'(DELAY_SLOTS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_pot              r_thr;
    logic [LEAK_W-1:0] r_leak;
    logic [STREN_W-1:0] r_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= t_pot'(4096);
            r_leak     <= '0;
            r_strength <= STREN_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRE_THRESHOLD: r_thr      <= i_cfg_data;
                CFG_LEAK_RATE:      r_leak     <= i_cfg_data[LEAK_W-1:0];
                CFG_SPIKE_STRENGTH: r_strength <= i_cfg_data[STREN_W-1:0];
                default:            ; // unused index: ignore
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, scale the product, pick the slot, start the RAM read
    // ------------------------------------------------------------------
    logic              in_acc;
    logic              s1_adv;
    logic              out_free;
    logic [SW-1:0]     r_head;
    logic [SW-1:0]     n_head;
    logic [SW-1:0]     delay_mod;
    logic [SW:0]       idx_sum;
    logic [SW-1:0]     spike_idx;
    logic [SW-1:0]     rd_addr;
    logic signed [PW-1:0] weight_prod;
    logic signed [PW-1:0] weight_scaled;

    assign in_acc = i_in_valid && !o_in_stall;

    assign delay_mod = DELAY_MOD[i_synapse_delay*SW +: SW];
    assign idx_sum   = {1'b0, r_head} + {1'b0, delay_mod};
    assign spike_idx = (idx_sum >= SLOTS_EXT) ? SW'(idx_sum - SLOTS_EXT) : idx_sum[SW-1:0];
    assign rd_addr   = (i_action == ACT_TICK) ? r_head : spike_idx;
    assign n_head    = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;

    // Floor scaling: arithmetic shift rounds toward minus infinity
    assign weight_prod   = PW'(i_synapse_weight) * PW'($signed({1'b0, i_sender_strength}));
    assign weight_scaled = weight_prod >>> FRACTION_BITS;

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    logic                 r_s1_valid;
    logic                 r_s1_tick;
    logic [SW-1:0]        r_s1_addr;
    logic signed [CW-1:0] r_contrib;
    logic                 r_fwd;
    t_pot                 r_fwd_data;
    logic                 r_rd_valid;
    logic [DELAY_SLOTS-1:0] r_slot_valid;
    t_pot                 ram_rdata;
    t_pot                 slot_wdata;

    // Stage 1 always moves on unless a tick meets a full, stalled result register
    assign s1_adv     = r_s1_valid && (!r_s1_tick || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_head       <= '0;
            r_slot_valid <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            // advance the ring as soon as the tick is taken in
            if (in_acc && i_action == ACT_TICK) begin
                r_head <= n_head;
            end
            if (s1_adv) begin
                r_slot_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    // Payload of stage 1; capture the bypass from the write landing this edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_tick  <= (i_action == ACT_TICK);
            r_s1_addr  <= rd_addr;
            r_contrib  <= CW'(weight_scaled);
            r_fwd      <= s1_adv && (r_s1_addr == rd_addr);
            r_fwd_data <= slot_wdata;
            r_rd_valid <= r_slot_valid[rd_addr];
        end
    end

    lifsd_ram #(
        .WIDTH (POT_W),
        .DEPTH (DELAY_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (slot_wdata),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 logic: slot update for arrivals, integrate/fire/leak for ticks
    // ------------------------------------------------------------------
    t_pot                  slot_cur;
    t_pot                  spike_sum;
    t_pot                  pot_sum;
    t_pot                  pot_kept;
    t_pot                  pot_leaked;
    logic                  fire;
    logic [LEAK_W-1:0]     leak_eff;
    logic [LEAK_W-1:0]     keep;
    logic signed [KW-1:0]  leak_prod;
    logic signed [KW-1:0]  leak_scaled;
    t_pot                  r_pot;

    // Slot never written since reset reads as zero
    assign slot_cur  = r_fwd ? r_fwd_data : (r_rd_valid ? ram_rdata : '0);
    assign spike_sum = sat32(t_pot_wide'(slot_cur) + t_pot_wide'(r_contrib));
    // Tick empties the slot it consumes
    assign slot_wdata = r_s1_tick ? '0 : spike_sum;

    assign pot_sum  = sat32(t_pot_wide'(r_pot) + t_pot_wide'(slot_cur));
    assign fire     = (pot_sum >= r_thr);
    assign pot_kept = fire ? '0 : pot_sum;

    // Leak above one acts as one
    assign leak_eff    = (r_leak > LEAK_ONE) ? LEAK_ONE : r_leak;
    assign keep        = LEAK_ONE - leak_eff;
    assign leak_prod   = KW'(pot_kept) * KW'($signed({1'b0, keep}));
    assign leak_scaled = leak_prod >>> LEAK_SHIFT;
    assign pot_leaked  = leak_scaled[POT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot <= '0;
        end else if (s1_adv && r_s1_tick) begin
            r_pot <= pot_leaked;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic               r_out_valid;
    logic               r_fired;
    logic [STREN_W-1:0] r_out_value;
    t_pot               r_pot_after;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_tick) begin
            r_fired     <= fire;
            r_out_value <= fire ? r_strength : '0;
            r_pot_after <= pot_leaked;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_fired           = r_fired;
    assign o_output_value    = r_out_value;
    assign o_potential_after = r_pot_after;

endmodule

FILE: src/lifsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lifsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lifsd_chk.sv
// Port-level checker for the delayed-synapse LIF neuron, bound to the top level.
// Depends on lifsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lifsd_chk
    import lifsd_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_fired,
    input logic [STREN_W-1:0]         o_output_value,
    input logic signed [POT_W-1:0]    o_potential_after
);

    // A waiting result stays offered
    `ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // A waiting result keeps its potential
    `ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_potential_after))

    // Input backs up only behind a full, stalled result register
    `ASSERT_ALWAYS(a_stall_cause, !o_in_stall || (o_out_valid && i_out_stall))

    // Firing clears the potential, so the leaked value is zero
    `ASSERT_ALWAYS(a_fire_clears, !(o_out_valid && o_fired) || o_potential_after == '0)

    // No spike, no output value
    `ASSERT_ALWAYS(a_quiet_zero, !(o_out_valid && !o_fired) || o_output_value == '0)

endmodule

bind lif_neuron_with_synaptic_delay lifsd_chk u_lifsd_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_fired           (o_fired),
    .o_output_value    (o_output_value),
    .o_potential_after (o_potential_after)
);
